/* hw/rtl/lzsr_pkg.sv */
// shared types and constants for the lzss ring decompressor
// request structs, controller state, command and status bundles
package lzsr_pkg;

  localparam int CNT_W = 29;
  localparam int LEN_W = 5;
  localparam logic [LEN_W-1:0] LEN_MIN = 5'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             data_valid;
    logic             run_end;
    logic             stream_end;
    logic [CNT_W-1:0] total_count;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF_HI
  } phase_t;

  typedef enum logic [1:0] {
    TOK_FLAG,
    TOK_LIT,
    TOK_REF_LO,
    TOK_REF_HI
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  typedef struct packed {
    logic take;
    logic push_lit;
    logic start_copy;
    logic push_copy;
    logic push_mark;
    logic run_end;
    logic stream_end;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    tok_t tok;
    logic in_last;
    logic room;
    logic copy_final;
    logic slot_free;
    logic last_r;
  } dp_stat_t;

endpackage

/* hw/rtl/lzsr_ram.sv */
// generic single write port ram with registered read (old data on collision)
// no dependencies
module lzsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lzsr_ctrl.sv */
// controller state machine for the lzss ring decompressor
// depends on lzsr_pkg; drives commands into lzsr_dp
module lzsr_ctrl
  import lzsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && stat.tok == TOK_REF_HI && stat.room) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (stat.slot_free && stat.copy_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = stat.slot_free;
        if (acc) begin
          cmd.take = 1'b1;
          case (stat.tok) inside
            TOK_LIT: begin
              if (stat.room) begin
                cmd.push_lit   = 1'b1;
                cmd.run_end    = 1'b1;
                cmd.stream_end = stat.in_last;
              end else begin
                cmd.push_mark = stat.in_last;
              end
              cmd.clear = stat.in_last;
            end
            TOK_REF_HI: begin
              if (stat.room) begin
                cmd.start_copy = 1'b1;
              end else begin
                cmd.push_mark = stat.in_last;
                cmd.clear     = stat.in_last;
              end
            end
            TOK_FLAG, TOK_REF_LO: begin
              cmd.push_mark = stat.in_last;
              cmd.clear     = stat.in_last;
            end
            default: cmd.take = 1'b1;
          endcase
        end
      end
      ST_COPY: begin
        if (stat.slot_free) begin
          cmd.push_copy  = 1'b1;
          cmd.run_end    = stat.copy_final;
          cmd.stream_end = stat.copy_final && stat.last_r;
          cmd.clear      = stat.copy_final && stat.last_r;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // a copy only runs while the limit leaves room
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> stat.room)
    else $error("copy running with no room below the limit");

  // a stalled copy keeps its place
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && !stat.slot_free) |=> (state_r == ST_COPY))
    else $error("copy left while the output was stalled");
`endif

endmodule

/* hw/rtl/lzsr_dp.sv */
// datapath: token parser, history ring with fill tracking, copy engine, output register
// depends on lzsr_pkg and lzsr_ram
module lzsr_dp
  import lzsr_pkg::*;
#(
  parameter int RING_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  logic             out_ready,
  output logic             out_valid,
  output out_item_t        out_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat
);

  localparam int AW = $clog2(RING_DEPTH);

  logic [CNT_W-1:0] limit_r, limit_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       flag_bits_r, flag_bits_nxt;
  logic [2:0]       flag_idx_r, flag_idx_nxt;
  logic [7:0]       ref_lo_r, ref_lo_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    wpos_r, wpos_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             last_r, last_nxt;
  logic             fwd_r, fwd_nxt;
  logic [7:0]       fwd_data_r, fwd_data_nxt;
  logic             zero_r, zero_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  tok_t             tok;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   count_ext_inc;
  logic [7:0]       copy_byte;
  logic [AW-1:0]    pos_in;
  logic [AW-1:0]    src_inc;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_q;
  logic             push_any;

  lzsr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    unique case (phase_r)
      PH_FLAG:   tok = TOK_FLAG;
      PH_TOKEN:  tok = flag_bits_r[flag_idx_r] ? TOK_LIT : TOK_REF_LO;
      PH_REF_HI: tok = TOK_REF_HI;
      default:   tok = TOK_FLAG;
    endcase
  end

  assign count_inc     = count_r + CNT_W'(1);
  assign count_ext_inc = {1'b0, count_r} + (CNT_W+1)'(1);
  assign copy_byte     = fwd_r ? fwd_data_r : (zero_r ? 8'h00 : ram_q);
  assign pos_in        = AW'({in_data.in_byte[3:0], ref_lo_r});
  assign src_inc       = src_r + AW'(1);
  assign push_any      = cmd.push_lit || cmd.push_copy || cmd.push_mark;

  assign stat.tok        = tok;
  assign stat.in_last    = in_data.in_last;
  assign stat.room       = count_r < limit_r;
  assign stat.copy_final = (rem_r == LEN_W'(1)) || (count_ext_inc >= {1'b0, limit_r});
  assign stat.slot_free  = !out_valid_r || out_ready;
  assign stat.last_r     = last_r;

  assign ram_we    = cmd.push_lit || cmd.push_copy;
  assign ram_wdata = cmd.push_lit ? in_data.in_byte : copy_byte;

  // read address runs one ahead of the byte being emitted
  always_comb begin
    if (cmd.start_copy) begin
      ram_raddr = pos_in;
    end else if (cmd.push_copy) begin
      ram_raddr = src_inc;
    end else begin
      ram_raddr = src_r;
    end
  end

  // entries never written this stream read as zero; same-cycle write is forwarded
  assign fwd_nxt      = cmd.push_copy && (src_inc == wpos_r);
  assign fwd_data_nxt = copy_byte;
  assign zero_nxt     = !(wrapped_r || (ram_raddr < wpos_r));

  always_comb begin
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    phase_nxt     = phase_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    ref_lo_nxt    = ref_lo_r;
    count_nxt     = count_r;
    wpos_nxt      = wpos_r;
    wrapped_nxt   = wrapped_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;

    if (cmd.take) begin
      case (tok) inside
        TOK_FLAG: begin
          flag_bits_nxt = in_data.in_byte;
          flag_idx_nxt  = 3'd0;
          phase_nxt     = PH_TOKEN;
        end
        TOK_REF_LO: begin
          ref_lo_nxt = in_data.in_byte;
          phase_nxt  = PH_REF_HI;
        end
        TOK_LIT, TOK_REF_HI: begin
          if (flag_idx_r == 3'd7) begin
            flag_idx_nxt = 3'd0;
            phase_nxt    = PH_FLAG;
          end else begin
            flag_idx_nxt = flag_idx_r + 3'd1;
            phase_nxt    = PH_TOKEN;
          end
        end
        default: phase_nxt = PH_FLAG;
      endcase
    end

    if (cmd.start_copy) begin
      src_nxt  = pos_in;
      rem_nxt  = LEN_W'(in_data.in_byte[7:4]) + LEN_MIN;
      last_nxt = in_data.in_last;
    end else if (cmd.push_copy) begin
      src_nxt = src_inc;
      rem_nxt = rem_r - LEN_W'(1);
    end

    if (ram_we) begin
      count_nxt   = count_inc;
      wpos_nxt    = wpos_r + AW'(1);
      wrapped_nxt = wrapped_r || (&wpos_r);
    end

    if (cmd.clear) begin
      phase_nxt     = PH_FLAG;
      flag_bits_nxt = 8'h00;
      flag_idx_nxt  = 3'd0;
      ref_lo_nxt    = 8'h00;
      count_nxt     = '0;
      wpos_nxt      = '0;
      wrapped_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.push_lit) begin
      out_data_nxt  = '{out_byte: in_data.in_byte, data_valid: 1'b1, run_end: cmd.run_end,
                        stream_end: cmd.stream_end, total_count: count_inc};
      out_valid_nxt = 1'b1;
    end else if (cmd.push_copy) begin
      out_data_nxt  = '{out_byte: copy_byte, data_valid: 1'b1, run_end: cmd.run_end,
                        stream_end: cmd.stream_end, total_count: count_inc};
      out_valid_nxt = 1'b1;
    end else if (cmd.push_mark) begin
      out_data_nxt  = '{out_byte: 8'h00, data_valid: 1'b0, run_end: 1'b1,
                        stream_end: 1'b1, total_count: count_r};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      phase_r     <= PH_FLAG;
      flag_bits_r <= 8'h00;
      flag_idx_r  <= 3'd0;
      ref_lo_r    <= 8'h00;
      count_r     <= '0;
      wpos_r      <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      phase_r     <= phase_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      ref_lo_r    <= ref_lo_nxt;
      count_r     <= count_nxt;
      wpos_r      <= wpos_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    last_r     <= last_nxt;
    fwd_r      <= fwd_nxt;
    fwd_data_r <= fwd_data_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // at most one thing happens to the ring and output per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push_lit, cmd.push_copy, cmd.push_mark, cmd.start_copy}))
    else $error("conflicting datapath commands");

  // never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    push_any |-> (!out_valid_r || out_ready))
    else $error("result pushed over a pending one");

  // a data byte always carries a non-zero running count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.data_valid) |-> (out_data_r.total_count != '0))
    else $error("data result with zero count");

  // end of stream is always the end of its input byte's run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.stream_end) |-> out_data_r.run_end)
    else $error("stream end without run end");
`endif

endmodule

/* hw/rtl/lzss_ring_decompressor_core.sv */
// LZSS decompressor with a history ring: one compressed byte per request in, one
// decompressed byte per request out. A reference high byte starts a copy of 3 to 18
// bytes (fewer at the output limit) through the single read port of the ring RAM,
// read one byte ahead with write forwarding so a copy emits one byte per cycle
// unless the output stalls. Outside a copy a new request is taken in the same cycle
// as a waiting result leaves the output register, and a stalled output simply holds
// the copy. The ring is not swept at reset or at a stream end: a fill pointer marks
// unwritten entries, which read as zero. The user must write output_limit through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
// depends on lzsr_pkg, lzsr_ctrl, lzsr_dp, lzsr_ram
module lzss_ring_decompressor_core
  import lzsr_pkg::*;
#(
  parameter int RING_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lzsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzsr_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
